/* hw/rtl/tkms_pkg.sv */
package tkms_pkg;

    // Number of cells in the chain; keep_count is clamped to this.
    localparam int MAX_KEEP = 16;

    localparam int SCORE_W = 17;
    localparam int COORD_W = 12;
    localparam int POS_W   = 2 * COORD_W;
    localparam int RANK_W  = 4;
    localparam int CNT_W   = 5;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [SCORE_W-1:0] ONE_FIXED = SCORE_W'(65536);

    // Register index, taken from paddr[2]
    localparam logic REG_KEEP_COUNT = 1'b0;
    localparam logic REG_START_THR  = 1'b1;

    localparam logic [CNT_W-1:0] KEEP_RESET = CNT_W'(4);

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [POS_W-1:0]   pos;    // row in upper half, column in lower half
    } entry_t;

    typedef struct packed {
        logic insert;   // new score offered to every cell
        logic shift;    // report: each cell takes its right neighbor
        logic clear;    // reload threshold and zero position
    } cell_ctrl_t;

    typedef struct packed {
        logic [CNT_W-1:0]   keep_n;     // clamped to 1..MAX_KEEP
        logic [SCORE_W-1:0] clr_score;  // saturated threshold
        logic               clear;      // register write this cycle
    } cfg_t;

    function automatic logic [SCORE_W-1:0] sat_one(input logic [SCORE_W-1:0] v);
        sat_one = (v > ONE_FIXED) ? ONE_FIXED : v;
    endfunction

endpackage

/* hw/rtl/tkms_cell.sv */
module tkms_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tkms_pkg::cell_ctrl_t          ctrl,
    input  tkms_pkg::entry_t              new_entry,
    input  logic [tkms_pkg::SCORE_W-1:0]  clr_score,
    input  logic                          prev_lt,
    input  tkms_pkg::entry_t              prev_entry,
    input  tkms_pkg::entry_t              next_entry,
    output logic                          lt,
    output tkms_pkg::entry_t              entry
);

    tkms_pkg::entry_t entry_reg;
    tkms_pkg::entry_t entry_next;

    // strict compare: ties keep the earlier entry
    assign lt    = new_entry.score < entry_reg.score;
    assign entry = entry_reg;

    always_comb begin
        entry_next = entry_reg;
        if (ctrl.clear) begin
            entry_next.score = clr_score;
            entry_next.pos   = '0;
        end else if (ctrl.shift) begin
            entry_next = next_entry;
        end else if (ctrl.insert) begin
            if (prev_lt) begin
                entry_next = prev_entry;
            end else if (lt) begin
                entry_next = new_entry;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg.score <= tkms_pkg::ONE_FIXED;
            entry_reg.pos   <= '0;
        end else begin
            entry_reg <= entry_next;
        end
    end

endmodule

/* hw/rtl/tkms_cfg.sv */
module tkms_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tkms_pkg::ADDR_W-1:0]  paddr,
    input  logic [tkms_pkg::DATA_W-1:0]  pwdata,
    output logic [tkms_pkg::DATA_W-1:0]  prdata,
    output tkms_pkg::cfg_t               cfg
);

    logic [tkms_pkg::CNT_W-1:0]   keep_reg;
    logic [tkms_pkg::CNT_W-1:0]   keep_next;
    logic [tkms_pkg::SCORE_W-1:0] thr_reg;
    logic [tkms_pkg::SCORE_W-1:0] thr_next;
    logic                         wr;
    logic                         idx;

    assign wr  = psel & penable & pwrite;
    assign idx = paddr[2];

    always_comb begin
        keep_next = keep_reg;
        thr_next  = thr_reg;
        if (wr) begin
            case (idx)
                tkms_pkg::REG_KEEP_COUNT: keep_next = pwdata[tkms_pkg::CNT_W-1:0];
                tkms_pkg::REG_START_THR:  thr_next  = pwdata[tkms_pkg::SCORE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            keep_reg <= tkms_pkg::KEEP_RESET;
            thr_reg  <= tkms_pkg::ONE_FIXED;
        end else begin
            keep_reg <= keep_next;
            thr_reg  <= thr_next;
        end
    end

    always_comb begin
        case (idx)
            tkms_pkg::REG_KEEP_COUNT:
                prdata = {{(tkms_pkg::DATA_W-tkms_pkg::CNT_W){1'b0}}, keep_reg};
            tkms_pkg::REG_START_THR:
                prdata = {{(tkms_pkg::DATA_W-tkms_pkg::SCORE_W){1'b0}}, thr_reg};
            default:
                prdata = '0;
        endcase
    end

    // clear value follows a threshold written this same cycle
    always_comb begin
        if (keep_reg == '0) begin
            cfg.keep_n = tkms_pkg::CNT_W'(1);
        end else if (keep_reg > tkms_pkg::CNT_W'(tkms_pkg::MAX_KEEP)) begin
            cfg.keep_n = tkms_pkg::CNT_W'(tkms_pkg::MAX_KEEP);
        end else begin
            cfg.keep_n = keep_reg;
        end
        cfg.clr_score = tkms_pkg::sat_one(thr_next);
        cfg.clear     = wr;
    end

endmodule

/* hw/rtl/top_k_min_score_tracker.sv */
// Channel  Dir  Handshake          Payload
// s_       in   s_tvalid/s_tready  s_tdata: score, pos_x, pos_y; s_tlast: frame_end
// m_       out  m_tvalid/m_tready  m_tdata: rank, kept_score, kept_x, kept_y;
//                                  m_tlast: last_result
// apb      in   psel/penable       keep_count @0x0, start_threshold @0x4
//
// Ordinary scores are taken one beat per cycle: every cell of the chain compares
// in parallel and the list shifts right by one cell behind the insert point.
// A frame_end beat is inserted like any other, then keep_count (clamped to
// 1..16) result beats follow, one per cycle while m_tready is high; the chain
// shifts toward cell 0, which drives m_tdata. s_tready is low for those beats.
// On the last result beat, and on any register write, all cells reload the
// threshold. Reset is synchronous; the list comes up at 1.0.
module top_k_min_score_tracker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [16:0] score, [28:17] pos_x, [40:29] pos_y, [47:41] zero
    input  logic [47:0] s_tdata,
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [3:0] rank, [20:4] kept_score, [32:21] kept_x, [44:33] kept_y, [47:45] zero
    output logic [47:0] m_tdata,
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int N = tkms_pkg::MAX_KEEP;
    localparam int SW = tkms_pkg::SCORE_W;
    localparam int CW = tkms_pkg::COORD_W;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_REPORT = 2'b10
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    logic [tkms_pkg::RANK_W-1:0] rank_reg;
    logic [tkms_pkg::RANK_W-1:0] rank_next;

    tkms_pkg::cfg_t       cfg;
    tkms_pkg::cell_ctrl_t ctrl;
    tkms_pkg::entry_t     new_entry;
    tkms_pkg::entry_t     tail_entry;
    tkms_pkg::entry_t     ent [N];
    tkms_pkg::entry_t     prev_ent [N];
    tkms_pkg::entry_t     next_ent [N];
    logic                 lt [N];
    logic                 prev_lt [N];

    logic s_acc;
    logic m_acc;
    logic last_beat;

    assign pready = 1'b1;

    tkms_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // incoming beat, score saturated at 1.0
    assign new_entry.score = tkms_pkg::sat_one(s_tdata[SW-1:0]);
    assign new_entry.pos   = {s_tdata[SW+2*CW-1:SW+CW], s_tdata[SW+CW-1:SW]};

    assign tail_entry.score = cfg.clr_score;
    assign tail_entry.pos   = '0;

    // neighbor wiring of the chain
    always_comb begin
        for (int i = 0; i < N; i++) begin
            if (i == 0) begin
                prev_lt[i]  = 1'b0;
                prev_ent[i] = new_entry;
            end else begin
                prev_lt[i]  = lt[i-1];
                prev_ent[i] = ent[i-1];
            end
            if (i == N - 1) begin
                next_ent[i] = tail_entry;
            end else begin
                next_ent[i] = ent[i+1];
            end
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_cell
        tkms_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .new_entry  (new_entry),
            .clr_score  (cfg.clr_score),
            .prev_lt    (prev_lt[g]),
            .prev_entry (prev_ent[g]),
            .next_entry (next_ent[g]),
            .lt         (lt[g]),
            .entry      (ent[g])
        );
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_REPORT);
    assign s_acc     = s_tvalid & s_tready;
    assign m_acc     = m_tvalid & m_tready;
    assign last_beat = ({1'b0, rank_reg} == (cfg.keep_n - tkms_pkg::CNT_W'(1)));

    assign ctrl.insert = s_acc;
    assign ctrl.shift  = m_acc;
    assign ctrl.clear  = (m_acc & last_beat) | cfg.clear;

    // cell 0 is the head of the list and the output stage
    assign m_tdata = {3'b000, ent[0].pos, ent[0].score, rank_reg};
    assign m_tlast = last_beat;

    always_comb begin
        state_next = state_reg;
        rank_next  = rank_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc && s_tlast) begin
                    state_next = ST_REPORT;
                    rank_next  = '0;
                end
            end
            ST_REPORT: begin
                if (m_acc) begin
                    rank_next = rank_reg + tkms_pkg::RANK_W'(1);
                    if (last_beat) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rank_reg  <= '0;
        end else begin
            state_reg <= state_next;
            rank_reg  <= rank_next;
        end
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input taken during report");

    a_report_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> (m_tvalid && m_tdata[3:0] == 4'd0))
        else $error("report did not start at rank 0");

    a_report_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
        else $error("block not idle after last result");

    a_rank_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ({1'b0, rank_reg} < cfg.keep_n))
        else $error("rank beyond keep count");

endmodule

/* tb/tkms_rank_checker.sv */
module tkms_rank_checker
    import tkms_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatch_count,
    output int          ranks_pending
);

    typedef struct packed {
        logic [RANK_W-1:0]  rank;
        logic [SCORE_W-1:0] score;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
    } rank_beat_t;

    rank_beat_t         report_q[$];
    logic [CNT_W-1:0]   keep_reg;
    logic [SCORE_W-1:0] thr_reg;
    logic [SCORE_W-1:0] list_score [MAX_KEEP];
    logic [POS_W-1:0]   list_pos   [MAX_KEEP];

    function automatic logic [SCORE_W-1:0] cap_at_one(input logic [SCORE_W-1:0] v);
        return (v > ONE_FIXED) ? ONE_FIXED : v;
    endfunction

    function automatic int kept_depth();
        if (keep_reg == 0)
            return 1;
        if (keep_reg > MAX_KEEP)
            return MAX_KEEP;
        return int'(keep_reg);
    endfunction

    task automatic reload_list();
        int i;
        for (i = 0; i < MAX_KEEP; i++) begin
            list_score[i] = cap_at_one(thr_reg);
            list_pos[i]   = '0;
        end
    endtask

    // insert before first strictly greater entry; on frame end dump and reload
    task automatic take_score(input logic [SCORE_W-1:0] raw, input logic [COORD_W-1:0] x,
                              input logic [COORD_W-1:0] y, input logic fend);
        int n;
        int slot;
        int i;
        int k;
        logic [SCORE_W-1:0] s;
        rank_beat_t r;
        n    = kept_depth();
        s    = cap_at_one(raw);
        slot = -1;
        for (i = 0; i < n; i++)
            if (slot < 0 && s < list_score[i])
                slot = i;
        if (slot >= 0) begin
            for (k = n - 1; k > slot; k--) begin
                list_score[k] = list_score[k-1];
                list_pos[k]   = list_pos[k-1];
            end
            list_score[slot] = s;
            list_pos[slot]   = {y, x};
        end
        if (fend) begin
            for (i = 0; i < n; i++) begin
                r.rank  = RANK_W'(i);
                r.score = list_score[i];
                r.x     = list_pos[i][COORD_W-1:0];
                r.y     = list_pos[i][POS_W-1:COORD_W];
                r.last  = (i == n - 1);
                report_q.push_back(r);
            end
            reload_list();
        end
    endtask

    task automatic check_beat(input logic [47:0] d, input logic last);
        rank_beat_t got;
        rank_beat_t want;
        got.rank  = d[3:0];
        got.score = d[20:4];
        got.x     = d[32:21];
        got.y     = d[44:33];
        got.last  = last;
        if (report_q.size() == 0) begin
            if (mismatch_count < 10)
                $display("unexpected rank beat: rank %0d score %0d x %0d y %0d last %0b",
                         got.rank, got.score, got.x, got.y, got.last);
            mismatch_count++;
        end else begin
            want = report_q.pop_front();
            if (got.rank !== want.rank || got.score !== want.score || got.x !== want.x ||
                got.y !== want.y || got.last !== want.last) begin
                if (mismatch_count < 10) begin
                    $display("rank beat mismatch: expected rank %0d score %0d x %0d y %0d last %0b",
                             want.rank, want.score, want.x, want.y, want.last);
                    $display("                    actual   rank %0d score %0d x %0d y %0d last %0b",
                             got.rank, got.score, got.x, got.y, got.last);
                end
                mismatch_count++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            keep_reg = KEEP_RESET;
            thr_reg  = ONE_FIXED;
            reload_list();
            report_q.delete();
        end else begin
            if (m_tvalid && m_tready)
                check_beat(m_tdata, m_tlast);
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_KEEP_COUNT)
                    keep_reg = pwdata[CNT_W-1:0];
                else
                    thr_reg = pwdata[SCORE_W-1:0];
                reload_list();
            end
            if (s_tvalid && s_tready)
                take_score(s_tdata[16:0], s_tdata[28:17], s_tdata[40:29], s_tlast);
        end
        ranks_pending = report_q.size();
    end

endmodule

/* tb/tb_top_k_min_score_tracker.sv */
module tb_top_k_min_score_tracker;
    import tkms_pkg::*;

    // cycles to let the chain reload after the last rank beat before a register write
    localparam int SETTLE_CYCLES = 4;
    // long receiver hold-off: report stalls, s_tready drops, sender keeps offering
    localparam int LONG_HOLD     = 120;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // [16:0] score, [28:17] pos_x, [40:29] pos_y, [47:41] zero
    logic [47:0] s_tdata;
    logic        s_tlast;   // frame_end
    logic        m_tvalid;
    logic        m_tready;
    // [3:0] rank, [20:4] kept_score, [32:21] kept_x, [44:33] kept_y, [47:45] zero
    logic [47:0] m_tdata;
    logic        m_tlast;   // last_result
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int mismatch_count;
    int ranks_pending;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_req;   // bumped by stimulus, each bump starts one long hold-off

    top_k_min_score_tracker uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    tkms_rank_checker chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .mismatch_count (mismatch_count),
        .ranks_pending  (ranks_pending)
    );

    always #1 aclk = ~aclk;

    // hard stop, far beyond the slowest legal run
    initial begin
        #400000;
        $display("top_k_min_score_tracker verification failed");
        $finish;
    end

    // receiver: random stalls per current mode, plus the long hold-off on request
    initial begin : ready_gen
        int hold_left;
        int hold_seen;
        m_tready  = 1'b0;
        hold_left = 0;
        hold_seen = 0;
        forever begin
            @(negedge aclk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // one input beat; entered and left at a falling edge, s_tvalid stays high on exit
    task automatic offer_score(input logic [SCORE_W-1:0] score, input logic [COORD_W-1:0] x,
                               input logic [COORD_W-1:0] y, input logic fend);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, y, x, score};
        s_tlast  <= fend;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // setup phase, access phase, then a quiet phase
    task automatic write_reg(input logic idx, input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    // stop offering and wait until every predicted rank beat came back
    task automatic settle();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (ranks_pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // mix of zero, exactly one, above one (saturates), repeated values for ties, and spread
    function automatic logic [SCORE_W-1:0] pick_score();
        case ($urandom_range(7))
            0:       return '0;
            1:       return ONE_FIXED;
            2:       return SCORE_W'($urandom_range(131071, 65537));
            3:       return SCORE_W'($urandom_range(3) * 16384 + 5);
            default: return SCORE_W'($urandom_range(65536));
        endcase
    endfunction

    task automatic send_frame(input int len, input bit closed);
        int i;
        for (i = 0; i < len; i++)
            offer_score(pick_score(), COORD_W'($urandom_range(4095)),
                        COORD_W'($urandom_range(4095)), closed && (i == len - 1));
    endtask

    function automatic logic [31:0] keep_word();
        logic [31:0] w;
        w = $urandom();
        case ($urandom_range(5))
            0:       w[CNT_W-1:0] = '0;                          // treated as 1
            1:       w[CNT_W-1:0] = CNT_W'(1);
            2:       w[CNT_W-1:0] = CNT_W'(MAX_KEEP);
            3:       w[CNT_W-1:0] = CNT_W'($urandom_range(31, 17)); // clamps to MAX_KEEP
            default: w[CNT_W-1:0] = CNT_W'($urandom_range(MAX_KEEP, 1));
        endcase
        return w;
    endfunction

    function automatic logic [31:0] thr_word();
        logic [31:0] w;
        w = $urandom();
        case ($urandom_range(4))
            0:       w[SCORE_W-1:0] = '0;
            1:       w[SCORE_W-1:0] = ONE_FIXED;
            2:       w[SCORE_W-1:0] = SCORE_W'($urandom_range(131071, 65537));
            default: w[SCORE_W-1:0] = SCORE_W'($urandom_range(65536));
        endcase
        return w;
    endfunction

    initial begin
        int mode;
        int phase;
        int sent;
        int len;
        aclk          = 1'b0;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 0;

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // --- directed, reset settings: keep 4, threshold 1.0 ---
        // saturating scores never enter, tie keeps the earlier entry,
        // fifth entry pushes the last one out
        offer_score(17'd100,    12'd0,    12'd0,    1'b0);
        offer_score(17'd65537,  12'd5,    12'd5,    1'b0);
        offer_score(17'd131071, 12'd4095, 12'd0,    1'b0);
        offer_score(17'd0,      12'd4095, 12'd4095, 1'b0);
        offer_score(17'd100,    12'd1,    12'd1,    1'b0);
        offer_score(17'd10,     12'd2,    12'd2,    1'b0);
        offer_score(17'd50,     12'd7,    12'd9,    1'b1);
        // frame end alone at 1.0: every rank reports the threshold and zero position
        offer_score(ONE_FIXED,  12'd4095, 12'd4095, 1'b1);
        offer_score(17'd65535,  12'd3,    12'd3,    1'b1);
        settle();

        // keep count zero acts as one
        write_reg(REG_KEEP_COUNT, 32'd0);
        offer_score(17'd500, 12'd1, 12'd2, 1'b0);
        offer_score(17'd400, 12'd3, 12'd4, 1'b0);
        offer_score(17'd600, 12'd5, 12'd6, 1'b1);
        settle();

        // oversized keep count and threshold above one both clamp
        write_reg(REG_KEEP_COUNT, 32'd31);
        write_reg(REG_START_THR,  32'd131071);
        offer_score(17'd1000,  12'd10,   12'd20,   1'b0);
        offer_score(17'd65535, 12'd4095, 12'd1,    1'b0);
        offer_score(17'd2000,  12'd1,    12'd4095, 1'b0);
        offer_score(17'd999,   12'd2730, 12'd1365, 1'b0);
        offer_score(ONE_FIXED, 12'd0,    12'd0,    1'b1);
        settle();

        // zero threshold: nothing can enter, not even a zero score
        write_reg(REG_START_THR, 32'd0);
        offer_score(17'd0, 12'd1365, 12'd2730, 1'b0);
        offer_score(17'd0, 12'd4095, 12'd4095, 1'b1);
        settle();

        // register write in mid-frame wipes the partial list
        write_reg(REG_KEEP_COUNT, 32'd17);
        write_reg(REG_START_THR,  32'd40000);
        offer_score(17'd30000, 12'd11, 12'd12, 1'b0);
        offer_score(17'd20000, 12'd13, 12'd14, 1'b0);
        settle();
        write_reg(REG_START_THR, 32'd30000);
        offer_score(17'd25000, 12'd15, 12'd16, 1'b1);
        settle();

        // --- random: three stall modes, four register settings each ---
        for (mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    send_idle_pct = 37;
                    recv_idle_pct = 61;
                end
                1: begin
                    send_idle_pct = 61;
                    recv_idle_pct = 37;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (phase = 0; phase < 4; phase++) begin
                settle();
                write_reg(REG_KEEP_COUNT, keep_word());
                write_reg(REG_START_THR,  thr_word());
                if (mode == 0 && phase == 1)
                    hold_req = hold_req + 1;
                sent = 0;
                while (sent < 34) begin
                    len = ($urandom_range(4) == 0) ? 1 : $urandom_range(24, 2);
                    // now and then leave a frame open; a frame end or reg write ends it
                    send_frame(len, $urandom_range(5) != 0);
                    sent += len;
                end
            end
        end
        // close out with one full frame so the tail is checked too
        send_frame(8, 1'b1);

        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (ranks_pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("top_k_min_score_tracker verification clean");
        end else begin
            $display("top_k_min_score_tracker verification failed");
        end
        $finish;
    end

endmodule
